FILE: design/mwc_pkg.sv
package mwc_pkg;

  // Default sizes of the search.
  localparam int TEXT_DEPTH_DEF  = 1024;
  localparam int PATTERN_MAX_DEF = 256;
  localparam int ALPHABET_DEF    = 256;

  // Number of distinct values an input symbol byte can carry.
  localparam int SYM_VALUES = 256;
  localparam int SYM_IN_W   = 8;

  // Need counts swing from +PATTERN_MAX down to -TEXT_DEPTH.
  localparam int NEED_MAG_DEF = (TEXT_DEPTH_DEF > PATTERN_MAX_DEF) ? TEXT_DEPTH_DEF
                                                                   : PATTERN_MAX_DEF;
  localparam int NEED_W_DEF   = $clog2(NEED_MAG_DEF + 1) + 1;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } need_ctl_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } txt_ctl_t;

endpackage

FILE: design/mwc_need_tbl.sv
module mwc_need_tbl import mwc_pkg::*; #(
  parameter int ALPHABET = ALPHABET_DEF,
  parameter int NEED_W   = NEED_W_DEF,
  localparam int SYM_W   = $clog2(ALPHABET)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  need_ctl_t         ctl,
  input  logic [SYM_W-1:0]  rd_addr,
  input  logic [SYM_W-1:0]  wr_addr,
  input  logic [NEED_W-1:0] wr_data,
  output logic [NEED_W-1:0] rd_data
);

  logic [NEED_W-1:0]   mem [ALPHABET];
  logic [NEED_W-1:0]   mem_q_r;
  logic                vld_q_r;
  logic [ALPHABET-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd) begin
      mem_q_r <= mem[rd_addr];
      vld_q_r <= vld_r[rd_addr];
    end
  end

  // An entry that has not been written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      vld_r <= '0;
    end else if (ctl.wr) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = vld_q_r ? mem_q_r : '0;

endmodule

FILE: design/mwc_text_buf.sv
module mwc_text_buf import mwc_pkg::*; #(
  parameter int TEXT_DEPTH = TEXT_DEPTH_DEF,
  parameter int SYM_W      = $clog2(ALPHABET_DEF),
  localparam int ADDR_W    = $clog2(TEXT_DEPTH)
) (
  input  logic              clk,
  input  txt_ctl_t          ctl,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [SYM_W-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [SYM_W-1:0]  rd_data
);

  logic [SYM_W-1:0] mem [TEXT_DEPTH];
  logic [SYM_W-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_q_r;

endmodule

FILE: design/minimum_window_cover_search.sv
// Pattern byte: ST_IDLE, ST_PAT_UPD; ST_IDLE alone when dropped. Text byte: ST_IDLE,
// ST_TXT_UPD, ST_CHK; ST_IDLE alone when the pattern is empty or the buffer is full; plus
// ST_DROP_SYM, ST_DROP_UPD, ST_CHK per byte leaving the window. Every byte enters once and
// leaves at most once. After the last text byte, ST_EMIT loads its result into the output.
// Reset is synchronous, active low. The need table is cleared at once by per-entry
// valid flops, both at reset and after each result, so there is no clearing pass.
module minimum_window_cover_search import mwc_pkg::*; #(
  parameter int TEXT_DEPTH  = TEXT_DEPTH_DEF,
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int ALPHABET    = ALPHABET_DEF,
  localparam int ADDR_W     = $clog2(TEXT_DEPTH),
  localparam int LEN_W      = $clog2(TEXT_DEPTH + 2)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_mode,
  input  logic [SYM_IN_W-1:0] in_symbol,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_found,
  output logic [ADDR_W-1:0]   out_start_res,
  output logic [LEN_W-1:0]    out_length,
  output logic                out_overflow
);

  localparam int SYM_W    = $clog2(ALPHABET);
  localparam int CNT_W    = $clog2(TEXT_DEPTH + 1);
  localparam int PL_W     = $clog2(PATTERN_MAX + 1);
  localparam int NEED_MAG = (TEXT_DEPTH > PATTERN_MAX) ? TEXT_DEPTH : PATTERN_MAX;
  localparam int NEED_W   = $clog2(NEED_MAG + 1) + 1;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_PAT_UPD  = 7'b0000010,
    ST_TXT_UPD  = 7'b0000100,
    ST_CHK      = 7'b0001000,
    ST_DROP_SYM = 7'b0010000,
    ST_DROP_UPD = 7'b0100000,
    ST_EMIT     = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [PL_W-1:0]    plen_r, plen_nxt;
  logic [PL_W-1:0]    matched_r, matched_nxt;
  logic [CNT_W-1:0]   next_pos_r, next_pos_nxt;
  logic [CNT_W-1:0]   ws_r, ws_nxt;
  logic [CNT_W-1:0]   right_r, right_nxt;
  logic [LEN_W-1:0]   best_len_r, best_len_nxt;
  logic [ADDR_W-1:0]  best_start_r, best_start_nxt;
  logic               ovf_r, ovf_nxt;
  logic               last_r, last_nxt;
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [ADDR_W-1:0]  out_start_r, out_start_nxt;
  logic [LEN_W-1:0]   out_length_r, out_length_nxt;
  logic               out_overflow_r, out_overflow_nxt;

  need_ctl_t          need_ctl;
  logic [SYM_W-1:0]   need_rd_addr;
  logic [NEED_W-1:0]  need_wr_data;
  logic [NEED_W-1:0]  need_rd_data;
  logic [NEED_W-1:0]  need_inc;
  logic [NEED_W-1:0]  need_dec;
  txt_ctl_t           txt_ctl;
  logic [ADDR_W-1:0]  txt_rd_addr;
  logic [SYM_W-1:0]   txt_rd_data;

  logic [SYM_W-1:0]   sym_mod [SYM_VALUES];
  logic [SYM_W-1:0]   sym_red;
  logic [LEN_W-1:0]   win_len;
  logic               accept;
  logic               found;
  logic               need_pos;
  logic               inc_pos;

  // Reduction of an input byte into the alphabet, as a constant lookup.
  for (genvar g = 0; g < SYM_VALUES; g++) begin : g_sym_mod
    assign sym_mod[g] = SYM_W'(g % ALPHABET);
  end

  assign sym_red  = sym_mod[in_symbol];
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign win_len  = LEN_W'(right_r) - LEN_W'(ws_r) + LEN_W'(1);
  assign found    = (best_len_r <= LEN_W'(TEXT_DEPTH));
  assign need_inc = need_rd_data + NEED_W'(1);
  assign need_dec = need_rd_data - NEED_W'(1);
  assign need_pos = !need_rd_data[NEED_W-1] && (need_rd_data != '0);
  assign inc_pos  = !need_inc[NEED_W-1] && (need_inc != '0);

  // The sequencer never reads a need entry in the same cycle as it writes one, so the
  // memory needs no forwarding path.
  always_comb begin
    state_nxt        = state_r;
    plen_nxt         = plen_r;
    matched_nxt      = matched_r;
    next_pos_nxt     = next_pos_r;
    ws_nxt           = ws_r;
    right_nxt        = right_r;
    best_len_nxt     = best_len_r;
    best_start_nxt   = best_start_r;
    ovf_nxt          = ovf_r;
    last_nxt         = last_r;
    sym_nxt          = sym_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_found_nxt    = out_found_r;
    out_start_nxt    = out_start_r;
    out_length_nxt   = out_length_r;
    out_overflow_nxt = out_overflow_r;
    need_ctl         = '0;
    need_rd_addr     = sym_red;
    need_wr_data     = need_inc;
    txt_ctl          = '0;
    txt_rd_addr      = ws_r[ADDR_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sym_nxt  = sym_red;
          last_nxt = in_last;
          if (!in_mode) begin
            if (next_pos_r == '0) begin
              if (plen_r >= PL_W'(PATTERN_MAX)) begin
                ovf_nxt = 1'b1;
              end else begin
                need_ctl.rd = 1'b1;
                state_nxt   = ST_PAT_UPD;
              end
            end
          end else if (next_pos_r >= CNT_W'(TEXT_DEPTH)) begin
            ovf_nxt = 1'b1;
            if (in_last) begin
              state_nxt = ST_EMIT;
            end
          end else begin
            txt_ctl.wr   = 1'b1;
            right_nxt    = next_pos_r;
            next_pos_nxt = next_pos_r + CNT_W'(1);
            if (plen_r != '0) begin
              need_ctl.rd = 1'b1;
              state_nxt   = ST_TXT_UPD;
            end else if (in_last) begin
              state_nxt = ST_EMIT;
            end
          end
        end
      end
      ST_PAT_UPD: begin
        need_ctl.wr  = 1'b1;
        need_wr_data = need_inc;
        plen_nxt     = plen_r + PL_W'(1);
        state_nxt    = ST_IDLE;
      end
      ST_TXT_UPD: begin
        need_ctl.wr  = 1'b1;
        need_wr_data = need_dec;
        if (need_pos) begin
          matched_nxt = matched_r + PL_W'(1);
        end
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if ((matched_r == plen_r) && (ws_r <= right_r)) begin
          if (win_len < best_len_r) begin
            best_len_nxt   = win_len;
            best_start_nxt = ws_r[ADDR_W-1:0];
          end
          txt_ctl.rd = 1'b1;
          state_nxt  = ST_DROP_SYM;
        end else begin
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_DROP_SYM: begin
        need_ctl.rd  = 1'b1;
        need_rd_addr = txt_rd_data;
        sym_nxt      = txt_rd_data;
        state_nxt    = ST_DROP_UPD;
      end
      ST_DROP_UPD: begin
        need_ctl.wr  = 1'b1;
        need_wr_data = need_inc;
        if (inc_pos) begin
          matched_nxt = matched_r - PL_W'(1);
        end
        ws_nxt    = ws_r + CNT_W'(1);
        state_nxt = ST_CHK;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt    = 1'b1;
          out_found_nxt    = found;
          out_start_nxt    = found ? best_start_r : '0;
          out_length_nxt   = found ? best_len_r : '0;
          out_overflow_nxt = ovf_r;
          // The query state returns to its reset values for the next search.
          need_ctl.clr   = 1'b1;
          plen_nxt       = '0;
          matched_nxt    = '0;
          next_pos_nxt   = '0;
          ws_nxt         = '0;
          best_len_nxt   = LEN_W'(TEXT_DEPTH + 1);
          best_start_nxt = '0;
          ovf_nxt        = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      plen_r       <= '0;
      matched_r    <= '0;
      next_pos_r   <= '0;
      ws_r         <= '0;
      best_len_r   <= LEN_W'(TEXT_DEPTH + 1);
      best_start_r <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      plen_r       <= plen_nxt;
      matched_r    <= matched_nxt;
      next_pos_r   <= next_pos_nxt;
      ws_r         <= ws_nxt;
      best_len_r   <= best_len_nxt;
      best_start_r <= best_start_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    right_r        <= right_nxt;
    last_r         <= last_nxt;
    sym_r          <= sym_nxt;
    out_found_r    <= out_found_nxt;
    out_start_r    <= out_start_nxt;
    out_length_r   <= out_length_nxt;
    out_overflow_r <= out_overflow_nxt;
  end

  mwc_need_tbl #(
    .ALPHABET (ALPHABET),
    .NEED_W   (NEED_W)
  ) u_need_tbl (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (need_ctl),
    .rd_addr (need_rd_addr),
    .wr_addr (sym_r),
    .wr_data (need_wr_data),
    .rd_data (need_rd_data)
  );

  mwc_text_buf #(
    .TEXT_DEPTH (TEXT_DEPTH),
    .SYM_W      (SYM_W)
  ) u_text_buf (
    .clk     (clk),
    .ctl     (txt_ctl),
    .wr_addr (next_pos_r[ADDR_W-1:0]),
    .wr_data (sym_red),
    .rd_addr (txt_rd_addr),
    .rd_data (txt_rd_data)
  );

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_start_res = out_start_r;
  assign out_length    = out_length_r;
  assign out_overflow  = out_overflow_r;

endmodule
